@@ hw/rtl/layout_bitmap_cast_checker_assert.svh @@
// assertion macros used by the checker module
`ifndef LAYOUT_BITMAP_CAST_CHECKER_ASSERT_SVH
`define LAYOUT_BITMAP_CAST_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LBCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbcc: same-cycle property violated");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LBCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lbcc: next-cycle property violated");

`endif

@@ hw/rtl/lbcc_pkg.sv @@
package lbcc_pkg;

  localparam int LAYOUT_BITS = 64;
  localparam int SIZE_BITS   = 32;
  // bit position inside a layout bitmap
  localparam int POS_BITS    = $clog2(LAYOUT_BITS);
  // product of two periods
  localparam int PROD_BITS   = 2 * POS_BITS;
  // object size in 8-byte words
  localparam int WORD_BITS   = SIZE_BITS - 3;
  localparam int CMP_BITS    = (WORD_BITS > PROD_BITS) ? WORD_BITS : PROD_BITS;

  typedef enum logic [1:0] {
    VERDICT_PASS      = 2'd0,
    VERDICT_MISMATCH  = 2'd1,
    VERDICT_SMALL     = 2'd2,
    VERDICT_MALFORMED = 2'd3
  } verdict_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_LOOP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic     load;
    logic     scan_step;
    logic     loop_init;
    logic     loop_step;
    logic     set_lay;
    logic     load_out;
    verdict_e lay;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic src_found;
    logic dst_found;
    logic words_zero;
    logic per_zero;
    logic loop_end;
    logic mismatch;
  } status_t;

endpackage

@@ hw/rtl/lbcc_datapath.sv @@
module lbcc_datapath (
  input  logic                                clk_i,
  input  logic [lbcc_pkg::LAYOUT_BITS-1:0]    src_layout_i,
  input  logic [lbcc_pkg::LAYOUT_BITS-1:0]    dst_layout_i,
  input  logic [lbcc_pkg::SIZE_BITS-1:0]      obj_size_i,
  input  logic [lbcc_pkg::SIZE_BITS-1:0]      min_size_i,
  input  lbcc_pkg::cmd_t                      cmd_i,
  output lbcc_pkg::status_t                   status_o,
  output logic [1:0]                          verdict_o
);

  logic [lbcc_pkg::LAYOUT_BITS-1:0] src_q, dst_q;
  logic [lbcc_pkg::SIZE_BITS-1:0]   osz_q, msz_q;
  logic [lbcc_pkg::POS_BITS-1:0]    scan_q;
  logic [lbcc_pkg::POS_BITS-1:0]    ps_q, pd_q;
  logic                             src_fnd_q, dst_fnd_q;
  logic [lbcc_pkg::POS_BITS-1:0]    is_q, id_q, is_d, id_d;
  logic [lbcc_pkg::PROD_BITS-1:0]   cnt_q, limit_q, limit_d;
  lbcc_pkg::verdict_e               lay_q, verdict_q, verdict_d;

  logic                             src_hit, dst_hit, src_fnd_d, dst_fnd_d;
  logic [lbcc_pkg::WORD_BITS-1:0]   words;
  logic [lbcc_pkg::PROD_BITS-1:0]   prod;
  logic [lbcc_pkg::CMP_BITS-1:0]    words_ext, prod_ext;
  logic [lbcc_pkg::POS_BITS:0]      is_inc, id_inc;

  always_comb begin
    src_hit   = src_q[scan_q];
    dst_hit   = dst_q[scan_q];
    src_fnd_d = src_fnd_q | src_hit;
    dst_fnd_d = dst_fnd_q | dst_hit;
    words     = osz_q[lbcc_pkg::SIZE_BITS-1:3];

    // compare at most one full period of both patterns
    prod      = {{lbcc_pkg::POS_BITS{1'b0}}, ps_q} * {{lbcc_pkg::POS_BITS{1'b0}}, pd_q};
    words_ext = lbcc_pkg::CMP_BITS'(words);
    prod_ext  = lbcc_pkg::CMP_BITS'(prod);
    limit_d   = (words_ext < prod_ext) ? lbcc_pkg::PROD_BITS'(words_ext) : prod;

    // phase counters wrap at their periods
    is_inc = {1'b0, is_q} + {{lbcc_pkg::POS_BITS{1'b0}}, 1'b1};
    id_inc = {1'b0, id_q} + {{lbcc_pkg::POS_BITS{1'b0}}, 1'b1};
    is_d   = (is_inc == {1'b0, ps_q}) ? '0 : is_inc[lbcc_pkg::POS_BITS-1:0];
    id_d   = (id_inc == {1'b0, pd_q}) ? '0 : id_inc[lbcc_pkg::POS_BITS-1:0];

    verdict_d = lay_q;
    if (lay_q == lbcc_pkg::VERDICT_PASS && osz_q < msz_q) begin
      verdict_d = lbcc_pkg::VERDICT_SMALL;
    end

    status_o.scan_end   = (src_fnd_d & dst_fnd_d) | (scan_q == '0);
    status_o.src_found  = src_fnd_q;
    status_o.dst_found  = dst_fnd_q;
    status_o.words_zero = (words == '0);
    status_o.per_zero   = (ps_q == '0) || (pd_q == '0);
    status_o.loop_end   = (cnt_q == limit_q);
    status_o.mismatch   = (src_q[is_q] != dst_q[id_q]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      src_q     <= src_layout_i;
      dst_q     <= dst_layout_i;
      osz_q     <= obj_size_i;
      msz_q     <= min_size_i;
      scan_q    <= lbcc_pkg::POS_BITS'(lbcc_pkg::LAYOUT_BITS - 1);
      src_fnd_q <= 1'b0;
      dst_fnd_q <= 1'b0;
      ps_q      <= '0;
      pd_q      <= '0;
    end
    // sentinel search, top bit down, one position a cycle
    if (cmd_i.scan_step) begin
      scan_q    <= scan_q - 1'b1;
      src_fnd_q <= src_fnd_d;
      dst_fnd_q <= dst_fnd_d;
      if (src_hit && !src_fnd_q) begin
        ps_q <= scan_q;
      end
      if (dst_hit && !dst_fnd_q) begin
        pd_q <= scan_q;
      end
    end
    if (cmd_i.loop_init) begin
      is_q    <= '0;
      id_q    <= '0;
      cnt_q   <= '0;
      limit_q <= limit_d;
    end
    if (cmd_i.loop_step) begin
      is_q  <= is_d;
      id_q  <= id_d;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.set_lay) begin
      lay_q <= cmd_i.lay;
    end
    if (cmd_i.load_out) begin
      verdict_q <= verdict_d;
    end
  end

  assign verdict_o = verdict_q;

endmodule

@@ hw/rtl/lbcc_ctrl.sv @@
module lbcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lbcc_pkg::status_t status_i,
  output lbcc_pkg::cmd_t    cmd_o
);

  lbcc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbcc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.lay = lbcc_pkg::VERDICT_PASS;

    case (state_q)
      lbcc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lbcc_pkg::ST_SCAN;
        end
      end
      lbcc_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_end) begin
          state_d = lbcc_pkg::ST_CHECK;
        end
      end
      lbcc_pkg::ST_CHECK: begin
        cmd_o.set_lay = 1'b1;
        if (!(status_i.src_found && status_i.dst_found)) begin
          cmd_o.lay = lbcc_pkg::VERDICT_MALFORMED;
          state_d   = lbcc_pkg::ST_FIN;
        end else if (status_i.words_zero) begin
          cmd_o.lay = lbcc_pkg::VERDICT_PASS;
          state_d   = lbcc_pkg::ST_FIN;
        end else if (status_i.per_zero) begin
          // sentinel only, but words to compare
          cmd_o.lay = lbcc_pkg::VERDICT_MALFORMED;
          state_d   = lbcc_pkg::ST_FIN;
        end else begin
          cmd_o.set_lay   = 1'b0;
          cmd_o.loop_init = 1'b1;
          state_d         = lbcc_pkg::ST_LOOP;
        end
      end
      lbcc_pkg::ST_LOOP: begin
        if (status_i.loop_end) begin
          cmd_o.set_lay = 1'b1;
          cmd_o.lay     = lbcc_pkg::VERDICT_PASS;
          state_d       = lbcc_pkg::ST_FIN;
        end else if (status_i.mismatch) begin
          cmd_o.set_lay = 1'b1;
          cmd_o.lay     = lbcc_pkg::VERDICT_MISMATCH;
          state_d       = lbcc_pkg::ST_FIN;
        end else begin
          cmd_o.loop_step = 1'b1;
        end
      end
      lbcc_pkg::ST_FIN: begin
        // output register free or being drained this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = lbcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lbcc_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != lbcc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/layout_bitmap_cast_checker.sv @@
// Layout bitmap cast checker. One request carries a source and a target layout
// bitmap (sentinel at the highest set bit, periodic pointer pattern below it),
// an object size and a required minimum size; one verdict comes back: pass,
// layout mismatch, object too small or malformed bitmap. Requests are handled
// one at a time. The sentinel search steps down from the top bit position to
// the lower of the two sentinels, one position a cycle for both bitmaps at
// once; when words are compared, the compare loop checks one 8-byte word a
// cycle, at most min(obj_size/8, Ps*Pd) words, up to the first mismatch.
// The verdict sits in an output register, so a new request is taken the cycle
// after the previous verdict is loaded there, whether or not it has been taken
// yet.
module layout_bitmap_cast_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lbcc_pkg::LAYOUT_BITS-1:0] src_layout_i,
  input  logic [lbcc_pkg::LAYOUT_BITS-1:0] dst_layout_i,
  input  logic [lbcc_pkg::SIZE_BITS-1:0]   obj_size_i,
  input  logic [lbcc_pkg::SIZE_BITS-1:0]   min_size_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       verdict_o
);

  lbcc_pkg::cmd_t    cmd;
  lbcc_pkg::status_t status;

  lbcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lbcc_datapath u_dp (
    .clk_i        (clk_i),
    .src_layout_i (src_layout_i),
    .dst_layout_i (dst_layout_i),
    .obj_size_i   (obj_size_i),
    .min_size_i   (min_size_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .verdict_o    (verdict_o)
  );

endmodule

@@ hw/rtl/lbcc_checker.sv @@
`include "layout_bitmap_cast_checker_assert.svh"

module lbcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] verdict_o
);

  // one request at a time: busy right after a request is taken
  `LBCC_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)

  // going idle always leaves a verdict in the output register
  `LBCC_ASSERT_NOW(a_idle_has_result, $fell(in_stall_o), out_valid_o)

  // a new verdict appears only at the end of a request
  `LBCC_ASSERT_NOW(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

  // a stalled verdict holds
  `LBCC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(verdict_o))

endmodule

bind layout_bitmap_cast_checker lbcc_checker u_lbcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o)
);

@@ test/layout_bitmap_cast_checker_tb.sv @@
module layout_bitmap_cast_checker_tb;

  localparam int unsigned RANDOM_ITEMS = 1525;
  localparam int unsigned SLACK_CYCLES = 20000;

  typedef struct {
    logic [lbcc_pkg::LAYOUT_BITS-1:0] src;
    logic [lbcc_pkg::LAYOUT_BITS-1:0] dst;
    logic [lbcc_pkg::SIZE_BITS-1:0]   osz;
    logic [lbcc_pkg::SIZE_BITS-1:0]   msz;
    bit                               known;
    lbcc_pkg::verdict_e               want;
  } cast_case_t;

  logic                             clk;
  logic                             rst_n;
  logic                             req_valid;
  logic                             in_stall;
  logic [lbcc_pkg::LAYOUT_BITS-1:0] src_layout;
  logic [lbcc_pkg::LAYOUT_BITS-1:0] dst_layout;
  logic [lbcc_pkg::SIZE_BITS-1:0]   obj_size;
  logic [lbcc_pkg::SIZE_BITS-1:0]   min_size;
  logic                             out_valid;
  logic                             out_stall;
  logic [1:0]                       verdict;

  // verdict typed into the directed table travels with the request
  bit                               req_known;
  lbcc_pkg::verdict_e               req_want;

  lbcc_pkg::verdict_e               verdict_fifo[$];
  int unsigned                      fault_cnt;
  longint unsigned                  cycle_cnt;
  longint unsigned                  cycle_budget;
  bit                               calm;
  bit                               long_hold_due;

  cast_case_t                       directed_cases [23];

  layout_bitmap_cast_checker dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (req_valid),
    .in_stall_o   (in_stall),
    .src_layout_i (src_layout),
    .dst_layout_i (dst_layout),
    .obj_size_i   (obj_size),
    .min_size_i   (min_size),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .verdict_o    (verdict)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int unsigned draw_wait();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // expected verdict of one cast check, plus the number of words compared
  function automatic lbcc_pkg::verdict_e predict_cast(
    input  logic [lbcc_pkg::LAYOUT_BITS-1:0] src,
    input  logic [lbcc_pkg::LAYOUT_BITS-1:0] dst,
    input  logic [lbcc_pkg::SIZE_BITS-1:0]   osz,
    input  logic [lbcc_pkg::SIZE_BITS-1:0]   msz,
    output int unsigned                      steps
  );
    int unsigned ps;
    int unsigned pd;
    int unsigned span;
    int unsigned i;
    logic [lbcc_pkg::SIZE_BITS-1:0] words;
    lbcc_pkg::verdict_e v;
    steps = 0;
    ps = 0;
    pd = 0;
    words = osz >> 3;
    v = lbcc_pkg::VERDICT_PASS;
    for (i = 0; i < lbcc_pkg::LAYOUT_BITS; i++) begin
      if (src[i]) ps = i;
      if (dst[i]) pd = i;
    end
    if (src == '0 || dst == '0) begin
      v = lbcc_pkg::VERDICT_MALFORMED;
    end else if (words != '0) begin
      if (ps == 0 || pd == 0) begin
        v = lbcc_pkg::VERDICT_MALFORMED;
      end else begin
        span = ps * pd;
        if (words < span) span = words;
        for (i = 0; i < span && v == lbcc_pkg::VERDICT_PASS; i++) begin
          steps++;
          if (src[i % ps] != dst[i % pd]) v = lbcc_pkg::VERDICT_MISMATCH;
        end
      end
    end
    if (v == lbcc_pkg::VERDICT_PASS && osz < msz) v = lbcc_pkg::VERDICT_SMALL;
    return v;
  endfunction

  task automatic send_request(input logic [lbcc_pkg::LAYOUT_BITS-1:0] src,
                              input logic [lbcc_pkg::LAYOUT_BITS-1:0] dst,
                              input logic [lbcc_pkg::SIZE_BITS-1:0]   osz,
                              input logic [lbcc_pkg::SIZE_BITS-1:0]   msz,
                              input bit                               known,
                              input lbcc_pkg::verdict_e               want);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_layout <= src;
    dst_layout <= dst;
    obj_size   <= osz;
    min_size   <= msz;
    req_known  <= known;
    req_want   <= want;
    req_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (verdict_fifo.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
  end

  initial begin
    while (cycle_cnt <= 4 * cycle_budget + SLACK_CYCLES) @(posedge clk);
    $display("layout_bitmap_cast_checker_tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin : verdict_monitor
    lbcc_pkg::verdict_e want;
    int unsigned        steps;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_fifo.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("verdict %0d with no request pending, cycle %0d", verdict, cycle_cnt);
      end else begin
        want = verdict_fifo.pop_front();
        if (verdict !== want) begin
          fault_cnt++;
          if (fault_cnt <= 10)
            $display("verdict mismatch, cycle %0d: expected %0d (%s), got %0d",
                     cycle_cnt, want, want.name(), verdict);
        end
      end
    end
    // pop before push so a stray verdict is never matched to a fresh request
    if (rst_n && req_valid && !in_stall) begin
      want = predict_cast(src_layout, dst_layout, obj_size, min_size, steps);
      if (req_known) want = req_want;
      verdict_fifo.push_back(want);
      cycle_budget += steps + 120;
    end
  end

  // result side: random hold-off per verdict, one long one on request
  initial begin : verdict_sink
    int unsigned hold;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_due) begin
        hold = 400;
        long_hold_due = 1'b0;
      end else begin
        hold = draw_wait();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : cast_stimulus
    logic [lbcc_pkg::LAYOUT_BITS-1:0] s;
    logic [lbcc_pkg::LAYOUT_BITS-1:0] d;
    logic [lbcc_pkg::SIZE_BITS-1:0]   o;
    logic [lbcc_pkg::SIZE_BITS-1:0]   m;
    logic [31:0]                      pat;
    int unsigned                      q;
    int unsigned                      ps;
    int unsigned                      pd;
    int unsigned                      reach;
    int unsigned                      b;
    int unsigned                      n;
    int unsigned                      kind;

    rst_n      <= 1'b0;
    req_valid  <= 1'b0;
    src_layout <= '0;
    dst_layout <= '0;
    obj_size   <= '0;
    min_size   <= '0;
    req_known  <= 1'b0;
    req_want   <= lbcc_pkg::VERDICT_PASS;
    fault_cnt     = 0;
    cycle_cnt     = 0;
    cycle_budget  = 0;
    calm          = 1'b0;
    long_hold_due = 1'b0;

    directed_cases = '{
      '{64'h0, 64'h5, 32'd16, 32'd0, 1'b1, lbcc_pkg::VERDICT_MALFORMED},
      '{64'h3, 64'h0, 32'd0, 32'd0, 1'b1, lbcc_pkg::VERDICT_MALFORMED},
      '{64'h0, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        lbcc_pkg::VERDICT_MALFORMED},
      '{64'h1, 64'h1, 32'd0, 32'd0, 1'b1, lbcc_pkg::VERDICT_PASS},
      '{64'h1, 64'h1, 32'd7, 32'd8, 1'b1, lbcc_pkg::VERDICT_SMALL},
      '{64'h1, 64'h2, 32'd8, 32'd0, 1'b1, lbcc_pkg::VERDICT_MALFORMED},
      '{64'h2, 64'h1, 32'd8, 32'd0, 1'b1, lbcc_pkg::VERDICT_MALFORMED},
      '{64'h6, 64'h1, 32'd7, 32'd0, 1'b1, lbcc_pkg::VERDICT_PASS},
      '{64'h3, 64'h2, 32'd8, 32'd0, 1'b1, lbcc_pkg::VERDICT_MISMATCH},
      // layout failure wins over a too-small object
      '{64'h3, 64'h2, 32'd8, 32'hFFFF_FFFF, 1'b1, lbcc_pkg::VERDICT_MISMATCH},
      '{64'h3, 64'h7, 32'd64, 32'd64, 1'b1, lbcc_pkg::VERDICT_PASS},
      '{64'h3, 64'h7, 32'd64, 32'd65, 1'b1, lbcc_pkg::VERDICT_SMALL},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        1'b1, lbcc_pkg::VERDICT_PASS},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'h3, 32'hFFFF_FFF8, 32'hFFFF_FFFF,
        1'b1, lbcc_pkg::VERDICT_SMALL},
      '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'd0,
        1'b1, lbcc_pkg::VERDICT_PASS},
      '{64'h8000_0000_0000_0001, 64'h2, 32'hFFFF_FFFF, 32'd0,
        1'b1, lbcc_pkg::VERDICT_MISMATCH},
      // pointer word at the end of a 63-word period, just inside and outside
      '{64'hC000_0000_0000_0000, 64'h2, 32'd496, 32'd0, 1'b0, lbcc_pkg::VERDICT_PASS},
      '{64'hC000_0000_0000_0000, 64'h2, 32'd504, 32'd0, 1'b0, lbcc_pkg::VERDICT_PASS},
      '{64'hB, 64'h5B, 32'd800, 32'd0, 1'b0, lbcc_pkg::VERDICT_PASS},
      '{64'h6, 64'hB, 32'd100, 32'd0, 1'b0, lbcc_pkg::VERDICT_PASS},
      '{64'h3, 64'h3, 32'd0, 32'hFFFF_FFFF, 1'b1, lbcc_pkg::VERDICT_SMALL},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h6, 32'hFFFF_FFFF, 32'd0,
        1'b0, lbcc_pkg::VERDICT_PASS},
      '{64'h4000_0000_0000_0000, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF,
        32'hFFFF_FFF0, 1'b0, lbcc_pkg::VERDICT_PASS}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_cases[i])
      send_request(directed_cases[i].src, directed_cases[i].dst, directed_cases[i].osz,
                   directed_cases[i].msz, directed_cases[i].known, directed_cases[i].want);
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 150) % 4 == 2);
      if (n == 400) long_hold_due = 1'b1;
      if (n == 900) drain_results();
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        // two bitmaps built from one short pattern, so the scan runs deep
        q = $urandom_range(1, 8);
        pat = $urandom;
        reach = ($urandom_range(0, 39) == 0) ? 63 : 16;
        ps = q * $urandom_range(1, reach / q);
        pd = q * $urandom_range(1, reach / q);
        s = '0;
        d = '0;
        for (b = 0; b < ps; b++) s[b] = pat[b % q];
        for (b = 0; b < pd; b++) d[b] = pat[b % q];
        s[ps] = 1'b1;
        d[pd] = 1'b1;
        if ($urandom_range(0, 4) == 0) begin
          b = $urandom_range(0, ps - 1);
          s[b] = ~s[b];
        end
        if ($urandom_range(0, 3) == 0) o = $urandom;
        else o = $urandom_range(0, ps * pd * 8 + 64);
        case ($urandom_range(0, 3))
          0:       m = $urandom;
          1:       m = o;
          default: m = o + $urandom_range(0, 16) - 8;
        endcase
      end else if (kind < 9) begin
        s = {$urandom, $urandom} >> $urandom_range(0, 63);
        d = {$urandom, $urandom} >> $urandom_range(0, 63);
        o = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 200);
        m = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 200);
      end else begin
        // one zero or sentinel-only bitmap, the other zero, sentinel-only or random, around small and large sizes
        case ($urandom_range(0, 1))
          0:       s = '0;
          default: s = 64'h1;
        endcase
        case ($urandom_range(0, 2))
          0:       d = '0;
          1:       d = 64'h1;
          default: d = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 1) == 0) begin
          s <<= 0;
          {s, d} = {d, s};
        end
        o = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15);
        m = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 15);
      end
      send_request(s, d, o, m, 1'b0, lbcc_pkg::VERDICT_PASS);
    end

    drain_results();
    repeat (80) @(posedge clk);
    if (fault_cnt == 0 && verdict_fifo.size() == 0) begin
      $display("layout_bitmap_cast_checker_tb: PASS");
    end else begin
      $display("layout_bitmap_cast_checker_tb: FAIL");
    end
    $finish;
  end

endmodule
